/* rtl/seven_segment_transition_frames_macros.svh */
// ----------------------------------------------------------------------------
// seven segment transition frames - assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TRANSITION_FRAMES_MACROS_SVH
`define SEVEN_SEGMENT_TRANSITION_FRAMES_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SSTF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sstf check failed");

// consequent must hold in the cycle after the antecedent
`define SSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sstf check failed");

`endif

/* rtl/sstf_pkg.sv */
// ----------------------------------------------------------------------------
// sstf_pkg
// word types and effect codes of the seven segment transition frame block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sstf_pkg;

    // effect codes
    localparam logic [3:0] OP_CUT          = 4'd0;
    localparam logic [3:0] OP_UP           = 4'd1;
    localparam logic [3:0] OP_DOWN         = 4'd2;
    localparam logic [3:0] OP_SCROLL_LEFT  = 4'd3;
    localparam logic [3:0] OP_SCROLL_RIGHT = 4'd4;
    localparam logic [3:0] OP_MIX_LEFT     = 4'd5;
    localparam logic [3:0] OP_MIX_RIGHT    = 4'd6;
    localparam logic [3:0] OP_FADE_IN      = 4'd7;
    localparam logic [3:0] OP_FADE_OUT     = 4'd8;

    localparam logic [1:0] LAST_FRAME_IDX  = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] old_d0;
        logic [7:0] old_d1;
        logic [7:0] old_d2;
        logic [7:0] old_d3;
        logic [7:0] new_d0;
        logic [7:0] new_d1;
        logic [7:0] new_d2;
        logic [7:0] new_d3;
    } t_item;

    typedef struct packed {
        logic [1:0] frame_index;
        logic [7:0] seg0;
        logic [7:0] seg1;
        logic [7:0] seg2;
        logic [7:0] seg3;
        logic       last_frame;
    } t_frame;

endpackage

`default_nettype wire

/* rtl/seven_segment_transition_frames.sv */
// ----------------------------------------------------------------------------
// seven_segment_transition_frames
// turns one transition request into four seven segment animation frames
// ----------------------------------------------------------------------------
// each accepted word (effect code, old and new four digit patterns) produces
// four result words, frame 0 first, with last_frame set on frame 3. the
// request is held in an input register while a two bit frame counter walks
// it through the frame logic into an output register, one frame per cycle
// when the downstream side keeps ready high. the next request is taken in
// the same cycle frame 3 moves to the output register, so back to back
// requests run with no gap. the first frame passes through the input
// register and then the output register before it appears.
// no state is kept between requests and there is no configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_transition_frames
    import sstf_pkg::*;
(
    input  var logic   i_clk,
    input  var logic   i_rst_n,
    // request side
    input  var logic   i_valid,
    output var logic   o_ready,
    input  var t_item  i_item,
    // frame side
    output var logic   o_valid,
    input  var logic   i_ready,
    output var t_frame o_frame
);

    // held request and frame counter
    logic       r_busy;
    logic       n_busy;
    t_item      r_item;
    logic [1:0] r_idx;
    logic [1:0] n_idx;

    // output register
    logic       r_out_valid;
    logic       n_out_valid;
    t_frame     r_out;

    logic       out_free;
    logic       advance;
    logic       last_adv;
    logic       accept;
    t_frame     calc_frame;

    // output register can load when empty or being emptied this cycle
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_busy && out_free;
    assign last_adv = advance && (r_idx == LAST_FRAME_IDX);

    // free for a new word when idle or when frame 3 is leaving now
    assign o_ready = !r_busy || last_adv;
    assign accept  = i_valid && o_ready;

    sstf_frame_calc u_frame_calc (
        .i_item  (r_item),
        .i_idx   (r_idx),
        .o_frame (calc_frame)
    );

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_idx       = r_idx + 2'd1;
            n_out_valid = 1'b1;
            if (last_adv) begin
                n_busy = 1'b0;
            end
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (advance) begin
            r_out <= calc_frame;
        end
    end

    assign o_valid = r_out_valid;
    assign o_frame = r_out;

endmodule

`default_nettype wire

/* rtl/sstf_frame_calc.sv */
// ----------------------------------------------------------------------------
// sstf_frame_calc
// builds one animation frame of a transition from the held word and index
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sstf_frame_calc
    import sstf_pkg::*;
(
    input  var t_item      i_item,
    input  var logic [1:0] i_idx,
    output var t_frame     o_frame
);

    localparam logic [7:0] SEG_A = 8'h01;
    localparam logic [7:0] SEG_D = 8'h08;
    localparam logic [7:0] SEG_G = 8'h40;
    localparam logic [7:0] BLANK = 8'h00;

    // C->B, E->F, G->A, D->G
    function automatic logic [7:0] roll_up(input logic [7:0] x);
        roll_up = {1'b0, x[3], x[4], 1'b0, 1'b0, 1'b0, x[2], x[6]};
    endfunction

    // B->C, F->E, A->G, G->D
    function automatic logic [7:0] roll_down(input logic [7:0] x);
        roll_down = {1'b0, x[0], 1'b0, x[5], x[6], x[1], 1'b0, 1'b0};
    endfunction

    logic [31:0] old_row;
    logic [31:0] new_row;
    logic [63:0] sl_all;
    logic [63:0] sr_all;
    logic [47:0] ml_all;
    logic [47:0] mr_all;
    logic [31:0] rows_ud;
    logic [31:0] rows_fade;
    logic [31:0] row;
    logic [7:0]  a_i;
    logic [7:0]  b_i;
    logic [7:0]  f1;

    assign old_row = {i_item.old_d3, i_item.old_d2, i_item.old_d1, i_item.old_d0};
    assign new_row = {i_item.new_d3, i_item.new_d2, i_item.new_d1, i_item.new_d0};

    // digit shifts as byte shifts over the joined sequence
    assign sl_all = {old_row, new_row} >> {(2'd3 - i_idx), 3'b000};
    assign sr_all = {new_row, old_row} >> {({1'b0, i_idx} + 3'd1), 3'b000};
    assign ml_all = {i_item.old_d3, i_item.old_d2,
                     i_item.old_d1 | i_item.new_d3, i_item.old_d0 | i_item.new_d2,
                     i_item.new_d1, i_item.new_d0} >> {(2'd2 - i_idx), 3'b000};
    assign mr_all = {i_item.new_d3, i_item.new_d2,
                     i_item.old_d3 | i_item.new_d1, i_item.old_d2 | i_item.new_d0,
                     i_item.old_d1, i_item.old_d0} >> {i_idx, 3'b000};

    // per digit roll and fade
    always_comb begin
        rows_ud   = '0;
        rows_fade = '0;
        a_i       = '0;
        b_i       = '0;
        f1        = '0;
        for (int i = 0; i < 4; i++) begin
            a_i = old_row[i*8 +: 8];
            b_i = new_row[i*8 +: 8];
            if (i_item.op == OP_UP) begin
                f1 = roll_up(a_i) | {4'b0000, b_i[0], 3'b000};
                case (i_idx)
                    2'd0:    rows_ud[i*8 +: 8] = a_i;
                    2'd1:    rows_ud[i*8 +: 8] = f1;
                    2'd2:    rows_ud[i*8 +: 8] = roll_up(f1)
                                 | {3'b000, b_i[5], b_i[6], b_i[1], 2'b00};
                    default: rows_ud[i*8 +: 8] = b_i;
                endcase
            end else begin
                f1 = roll_down(a_i) | {7'b0000000, b_i[3]};
                case (i_idx)
                    2'd0:    rows_ud[i*8 +: 8] = a_i;
                    2'd1:    rows_ud[i*8 +: 8] = f1;
                    2'd2:    rows_ud[i*8 +: 8] = roll_down(f1)
                                 | {2'b00, b_i[4], 3'b000, b_i[2], b_i[6]};
                    default: rows_ud[i*8 +: 8] = b_i;
                endcase
            end
            if (i_item.op == OP_FADE_IN) begin
                case (i_idx)
                    2'd0:    rows_fade[i*8 +: 8] = BLANK;
                    2'd1:    rows_fade[i*8 +: 8] = SEG_G;
                    2'd2:    rows_fade[i*8 +: 8] = b_i & ~(SEG_A | SEG_D);
                    default: rows_fade[i*8 +: 8] = b_i & ~SEG_A;
                endcase
            end else begin
                case (i_idx)
                    2'd0:    rows_fade[i*8 +: 8] = a_i & ~SEG_A;
                    2'd1:    rows_fade[i*8 +: 8] = a_i & ~(SEG_A | SEG_D);
                    2'd2:    rows_fade[i*8 +: 8] = SEG_G;
                    default: rows_fade[i*8 +: 8] = BLANK;
                endcase
            end
        end
    end

    // effect select, unknown codes behave as cut
    always_comb begin
        unique case (i_item.op) inside
            OP_UP, OP_DOWN:           row = rows_ud;
            OP_FADE_IN, OP_FADE_OUT:  row = rows_fade;
            OP_SCROLL_LEFT:           row = sl_all[31:0];
            OP_SCROLL_RIGHT:          row = sr_all[31:0];
            OP_MIX_LEFT:              row = (i_idx == LAST_FRAME_IDX) ? new_row
                                                                      : ml_all[31:0];
            OP_MIX_RIGHT:             row = (i_idx == LAST_FRAME_IDX) ? new_row
                                                                      : mr_all[31:0];
            default:                  row = new_row;
        endcase
    end

    assign o_frame.frame_index = i_idx;
    assign o_frame.seg0        = row[7:0];
    assign o_frame.seg1        = row[15:8];
    assign o_frame.seg2        = row[23:16];
    assign o_frame.seg3        = row[31:24];
    assign o_frame.last_frame  = (i_idx == LAST_FRAME_IDX);

endmodule

`default_nettype wire

/* rtl/sstf_checker.sv */
// ----------------------------------------------------------------------------
// sstf_checker
// port level checks of the transition frame block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "seven_segment_transition_frames_macros.svh"

module sstf_checker
    import sstf_pkg::*;
(
    input  var logic   i_clk,
    input  var logic   i_rst_n,
    input  var logic   i_valid,
    input  var logic   o_ready,
    input  var t_item  i_item,
    input  var logic   o_valid,
    input  var logic   i_ready,
    input  var t_frame o_frame
);

    logic       in_take;
    logic       in_wait;
    logic       out_take;
    logic       out_wait;
    logic       is_last;
    logic       seq_head;
    logic       seq_next;
    logic [1:0] r_idx_next;

    assign in_take  = i_valid && o_ready;
    assign in_wait  = i_valid && !o_ready;
    assign out_take = o_valid && i_ready;
    assign out_wait = o_valid && !i_ready;
    assign is_last  = (o_frame.frame_index == LAST_FRAME_IDX);
    assign seq_head = out_take && !o_frame.last_frame;
    assign seq_next = o_valid && (o_frame.frame_index == r_idx_next);

    // index the following frame word must carry
    always_ff @(posedge i_clk) begin
        r_idx_next <= o_frame.frame_index + 2'd1;
    end

    // a stalled request word holds
    `SSTF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_valid && $stable(i_item))

    // a stalled word holds
    `SSTF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_valid && $stable(o_frame))

    // frames of one run follow each other with no gap
    `SSTF_ASSERT_NEXT(a_frame_seq, i_clk, i_rst_n, seq_head, seq_next)

    // last flag marks frame 3 only
    `SSTF_ASSERT_SAME(a_last_flag, i_clk, i_rst_n, o_valid, o_frame.last_frame == is_last)

    // a fresh request keeps ready low in the cycle after it is taken
    `SSTF_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, !o_ready)

endmodule

bind seven_segment_transition_frames sstf_checker u_sstf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_frame (o_frame)
);

`default_nettype wire
